[src/hjn_pkg.sv]
// Shared types and codes for the bucketed hash join engine.
`timescale 1ns / 1ps
package hjn_pkg;

  typedef enum logic [1:0] {
    REQ_BUILD = 2'd0,
    REQ_PROBE = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4,
    ST_TRUNC   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_HEAD,
    BK_OCC,
    BK_DECIDE,
    BK_RD,
    BK_CHK,
    BK_EMIT
  } bk_state_e;

  localparam int unsigned IdxW = 12;

  typedef struct packed {
    req_e        req;
    logic [31:0] key;
    logic [31:0] val;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic [31:0]     inner_key;
    logic [31:0]     inner_val;
    logic [IdxW-1:0] inner_index;
    logic [31:0]     outer_key;
    logic [31:0]     outer_val;
    logic            last;
  } res_t;

endpackage

[src/hjn_fifo.sv]
// Two-entry word queue used between the front, the back and the result port.
`timescale 1ns / 1ps
module hjn_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

[src/hjn_front.sv]
// Front end: takes request words, drops unknown codes and computes the bucket.
`timescale 1ns / 1ps
module hjn_front
  import hjn_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned BKT_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [1:0]       req_type_i,
  input  logic [31:0]      tuple_key_i,
  input  logic [31:0]      tuple_val_i,
  output logic             cmd_push_o,
  output cmd_t             cmd_o,
  output logic [BKT_W-1:0] cmd_bkt_o,
  input  logic             cmd_full_i
);

  localparam bit BktPow2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam int unsigned ShW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned RecipSh = 32 + ShW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecipSh) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [32:0] Recip = RecipFull[32:0];

  logic             busy_q;
  logic [1:0]       req_q;
  logic [31:0]      key_q, val_q;
  logic [BKT_W-1:0] rem_q, rem_d;
  logic [1:0]       phase_q;
  logic [48:0]      plo_q, plo_d;
  logic [47:0]      phi_q, phi_d;
  logic [31:0]      quo_q, quo_d;
  logic             done, req_ok, accept, leave;
  logic [65:0]      sum;
  logic [31:0]      prod, diff;
  logic [31:0]      masked;

  assign full_o = busy_q;
  assign accept = push_i && !busy_q;
  assign done   = BktPow2 || (phase_q == 2'd0);
  assign req_ok = (req_q == REQ_BUILD) || (req_q == REQ_PROBE) || (req_q == REQ_CLEAR);
  assign leave  = busy_q && done && (!req_ok || !cmd_full_i);

  // remainder by reciprocal multiply: partial products, quotient, value - q*N
  always_comb begin
    plo_d = 49'(val_q) * 49'(Recip[16:0]);
    phi_d = 48'(val_q) * 48'(Recip[32:17]);
    sum   = 66'({phi_q, 17'd0}) + 66'(plo_q);
    quo_d = 32'(sum >> RecipSh);
    prod  = quo_q * 32'(NUM_BUCKETS);
    diff  = val_q - prod;
    rem_d = diff[BKT_W-1:0];
  end

  assign masked     = val_q & 32'(NUM_BUCKETS - 1);
  assign cmd_push_o = busy_q && done && req_ok;
  assign cmd_o      = '{req: req_e'(req_q), key: key_q, val: val_q};
  assign cmd_bkt_o  = BktPow2 ? masked[BKT_W-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      req_q   <= 2'd0;
      key_q   <= '0;
      val_q   <= '0;
      rem_q   <= '0;
      phase_q <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      quo_q   <= '0;
    end else if (accept) begin
      busy_q  <= 1'b1;
      req_q   <= req_type_i;
      key_q   <= tuple_key_i;
      val_q   <= tuple_val_i;
      rem_q   <= '0;
      phase_q <= BktPow2 ? 2'd0 : 2'd3;
    end else if (leave) begin
      busy_q <= 1'b0;
    end else if (busy_q && !done) begin
      if (phase_q == 2'd3) begin
        plo_q <= plo_d;
        phi_q <= phi_d;
      end
      if (phase_q == 2'd2) quo_q <= quo_d;
      if (phase_q == 2'd1) rem_q <= rem_d;
      phase_q <= phase_q - 2'd1;
    end
  end

endmodule

[src/hjn_back.sv]
// Back end: bucket chain tables, build insertion and probe chain walk.
`timescale 1ns / 1ps
module hjn_back
  import hjn_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned MAX_RUN = 64,
  parameter int unsigned BKT_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  cmd_t             cmd_i,
  input  logic [BKT_W-1:0] cmd_bkt_i,
  output logic             cmd_pop_o,
  output logic             res_push_o,
  output res_t             res_o,
  input  logic             res_full_i
);

  localparam int unsigned SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RunW  = $clog2(MAX_RUN + 1);

  bk_state_e state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [BKT_W-1:0] bkt_q, bkt_d;
  logic [BKT_W-1:0] init_q, init_d;
  logic [SlotW:0]   count_q, count_d, steps_q, steps_d;
  logic [SlotW-1:0] cur_q, cur_d, pidx_q, pidx_d;
  logic [31:0]      pkey_q, pkey_d, pval_q, pval_d;
  logic [RunW-1:0]  nhits_q, nhits_d;
  res_t             res_q, res_d;

  logic [31:0]      key_mem  [TABLE_DEPTH];
  logic [31:0]      val_mem  [TABLE_DEPTH];
  logic [SlotW-1:0] next_mem [TABLE_DEPTH];
  logic [BKT_W-1:0] sbkt_mem [TABLE_DEPTH];
  logic [SlotW-1:0] head_mem [NUM_BUCKETS];
  logic [SlotW-1:0] tail_mem [NUM_BUCKETS];

  logic [SlotW-1:0] head_rd_q, tail_rd_q, nxt_rd_q;
  logic [BKT_W-1:0] sbkt_rd_q;
  logic [31:0]      key_rd_q, val_rd_q;

  logic             wr_tuple, wr_next, wr_head, wr_tail;
  logic [BKT_W-1:0] head_wa;
  logic [SlotW-1:0] head_wd;
  logic [SlotW-1:0] slot;
  logic             occupied, is_full, hit, walk_end;

  assign slot    = count_q[SlotW-1:0];
  // head is live only if it was filled since the last clear and belongs here
  assign occupied = ({1'b0, head_rd_q} < count_q) && (sbkt_rd_q == bkt_q);
  assign is_full  = count_q >= (SlotW + 1)'(TABLE_DEPTH);
  assign hit      = (val_rd_q == cmd_q.val);
  assign walk_end = (cur_q == tail_rd_q) || (steps_q + 1'b1 >= (SlotW + 1)'(TABLE_DEPTH))
                    || ({1'b0, nxt_rd_q} >= (SlotW + 1)'(TABLE_DEPTH));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    bkt_d      = bkt_q;
    init_d     = init_q;
    count_d    = count_q;
    steps_d    = steps_q;
    cur_d      = cur_q;
    nhits_d    = nhits_q;
    pkey_d     = pkey_q;
    pval_d     = pval_q;
    pidx_d     = pidx_q;
    res_d      = res_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = res_q;
    wr_tuple   = 1'b0;
    wr_next    = 1'b0;
    wr_head    = 1'b0;
    wr_tail    = 1'b0;
    head_wa    = bkt_q;
    head_wd    = slot;
    unique case (state_q)
      // one pass over the bucket heads so the occupancy check never reads X
      BK_INIT: begin
        wr_head = 1'b1;
        head_wa = init_q;
        head_wd = '0;
        init_d  = init_q + BKT_W'(1);
        if (init_q == BKT_W'(NUM_BUCKETS - 1)) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          bkt_d     = cmd_bkt_i;
          if (cmd_i.req == REQ_CLEAR) begin
            count_d = '0;
            res_d   = '{ST_CLEARED, 32'd0, 32'd0, '0, 32'd0, 32'd0, 1'b1};
            state_d = BK_EMIT;
          end else begin
            state_d = BK_HEAD;
          end
        end
      end
      BK_HEAD: state_d = BK_OCC;
      BK_OCC:  state_d = BK_DECIDE;
      BK_DECIDE: begin
        state_d = BK_EMIT;
        if (cmd_q.req == REQ_BUILD) begin
          if (is_full) begin
            res_d = '{ST_FULL, cmd_q.key, cmd_q.val, '0, 32'd0, 32'd0, 1'b1};
          end else begin
            wr_tuple = 1'b1;
            wr_next  = occupied;
            wr_head  = !occupied;
            wr_tail  = 1'b1;
            count_d  = count_q + 1'b1;
            res_d    = '{ST_STORED, cmd_q.key, cmd_q.val, IdxW'(slot), 32'd0, 32'd0, 1'b1};
          end
        end else if (!occupied) begin
          res_d = '{ST_NOMATCH, 32'd0, 32'd0, '0, cmd_q.key, cmd_q.val, 1'b1};
        end else begin
          cur_d   = head_rd_q;
          steps_d = '0;
          nhits_d = '0;
          state_d = BK_RD;
        end
      end
      BK_RD: state_d = BK_CHK;
      BK_CHK: begin
        // one match is held back so the final one can carry last
        if (hit && nhits_q == RunW'(MAX_RUN)) begin
          res_d   = '{ST_TRUNC, 32'd0, 32'd0, '0, cmd_q.key, cmd_q.val, 1'b1};
          state_d = BK_EMIT;
        end else if (!(hit && nhits_q != '0 && res_full_i)) begin
          if (hit) begin
            if (nhits_q != '0) begin
              res_push_o = 1'b1;
              res_o = '{ST_MATCH, pkey_q, pval_q, IdxW'(pidx_q), cmd_q.key, cmd_q.val, 1'b0};
            end
            nhits_d = nhits_q + 1'b1;
            pkey_d  = key_rd_q;
            pval_d  = val_rd_q;
            pidx_d  = cur_q;
          end
          if (walk_end) begin
            state_d = BK_EMIT;
            if (nhits_d == '0)
              res_d = '{ST_NOMATCH, 32'd0, 32'd0, '0, cmd_q.key, cmd_q.val, 1'b1};
            else
              res_d = '{ST_MATCH, pkey_d, pval_d, IdxW'(pidx_d), cmd_q.key, cmd_q.val, 1'b1};
          end else begin
            cur_d   = nxt_rd_q;
            steps_d = steps_q + 1'b1;
            state_d = BK_RD;
          end
        end
      end
      BK_EMIT: begin
        res_push_o = 1'b1;
        if (!res_full_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      init_q  <= '0;
      count_q <= '0;
      cmd_q   <= '0;
      bkt_q   <= '0;
      steps_q <= '0;
      cur_q   <= '0;
      nhits_q <= '0;
      pkey_q  <= '0;
      pval_q  <= '0;
      pidx_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      count_q <= count_d;
      cmd_q   <= cmd_d;
      bkt_q   <= bkt_d;
      steps_q <= steps_d;
      cur_q   <= cur_d;
      nhits_q <= nhits_d;
      pkey_q  <= pkey_d;
      pval_q  <= pval_d;
      pidx_q  <= pidx_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_tuple) begin
      key_mem[slot]  <= cmd_q.key;
      val_mem[slot]  <= cmd_q.val;
      sbkt_mem[slot] <= bkt_q;
    end
    if (wr_next) next_mem[tail_rd_q] <= slot;
    if (wr_head) head_mem[head_wa] <= head_wd;
    if (wr_tail) tail_mem[bkt_q] <= slot;
    head_rd_q <= head_mem[bkt_q];
    tail_rd_q <= tail_mem[bkt_q];
    sbkt_rd_q <= sbkt_mem[head_rd_q];
    key_rd_q  <= key_mem[cur_q];
    val_rd_q  <= val_mem[cur_q];
    nxt_rd_q  <= next_mem[cur_q];
  end

endmodule

[src/bucketed_hash_join.sv]
// Top level of the bucketed hash join engine.
//
// Request channel: push/full queue. req_type_i selects build (store an inner
// tuple), probe (look up an outer tuple) or clear; code 3 is dropped silently.
// Result channel: empty/pop queue; the oldest word sits on the result ports
// while empty is low. Every request except an unknown one yields a run of
// words ending with last_o set.
// The front takes a new request only once the last one has left it; when
// NUM_BUCKETS is not a power of two it first finds the bucket by a
// reciprocal multiply (partial products, quotient, remainder).
// A two-word queue decouples it from the back. A build passes through the
// head read, occupancy check, decide and emit states, a clear goes straight
// to emit, and a probe walks the bucket chain with one table read per entry.
// A probe run is cut at MAX_RUN words with a truncated status.
// After reset the back writes every bucket head once before it takes a
// request; the fill count returns to zero. If pop stays low, the two-word
// result queue fills, the back stops, then the request queue fills and
// full rises.
`timescale 1ns / 1ps
module bucketed_hash_join
  import hjn_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned MAX_RUN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] tuple_key_i,
  input  logic [31:0] tuple_val_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [31:0] inner_key_o,
  output logic [31:0] inner_val_o,
  output logic [11:0] inner_index_o,
  output logic [31:0] outer_key_o,
  output logic [31:0] outer_val_o,
  output logic        last_o
);

  localparam int unsigned BktW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CmdW = $bits(cmd_t) + BktW;

  logic            f_push, q_full, q_empty, q_pop;
  cmd_t            f_cmd, q_cmd;
  logic [BktW-1:0] f_bkt, q_bkt;
  logic [CmdW-1:0] q_word;
  logic            r_push, r_full;
  res_t            r_word, out_word;

  hjn_front #(.NUM_BUCKETS(NUM_BUCKETS), .BKT_W(BktW)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .req_type_i, .tuple_key_i, .tuple_val_i,
    .cmd_push_o(f_push), .cmd_o(f_cmd), .cmd_bkt_o(f_bkt), .cmd_full_i(q_full)
  );

  hjn_fifo #(.WIDTH(CmdW)) u_cmd_q (
    .clk_i, .rst_ni,
    .push_i(f_push), .wdata_i({f_cmd, f_bkt}), .full_o(q_full),
    .pop_i(q_pop), .rdata_o(q_word), .empty_o(q_empty)
  );

  assign q_cmd = q_word[CmdW-1:BktW];
  assign q_bkt = q_word[BktW-1:0];

  hjn_back #(
    .NUM_BUCKETS(NUM_BUCKETS), .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_RUN(MAX_RUN), .BKT_W(BktW)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i(q_empty), .cmd_i(q_cmd), .cmd_bkt_i(q_bkt), .cmd_pop_o(q_pop),
    .res_push_o(r_push), .res_o(r_word), .res_full_i(r_full)
  );

  hjn_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk_i, .rst_ni,
    .push_i(r_push), .wdata_i(r_word), .full_o(r_full),
    .pop_i(pop), .rdata_o(out_word), .empty_o(empty)
  );

  assign status_o      = out_word.status;
  assign inner_key_o   = out_word.inner_key;
  assign inner_val_o   = out_word.inner_val;
  assign inner_index_o = out_word.inner_index;
  assign outer_key_o   = out_word.outer_key;
  assign outer_val_o   = out_word.outer_val;
  assign last_o        = out_word.last;

endmodule

[src/hjn_checker.sv]
// Port-level checks for the hash join engine, bound to the top level.
`timescale 1ns / 1ps
module hjn_checker
  import hjn_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status_o,
  input logic [31:0] outer_key_o,
  input logic [31:0] outer_val_o,
  input logic [31:0] inner_key_o,
  input logic [11:0] inner_index_o,
  input logic        last_o
);

  // only match words may leave a run open
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != ST_MATCH |-> last_o)
    else $error("non-match word without last");

  a_build_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (status_o == ST_STORED || status_o == ST_FULL || status_o == ST_CLEARED)
    |-> outer_key_o == 32'd0 && outer_val_o == 32'd0)
    else $error("outer fields set on build or clear word");

  a_inner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (status_o == ST_NOMATCH || status_o == ST_TRUNC || status_o == ST_CLEARED)
    |-> inner_key_o == 32'd0 && inner_index_o == 12'd0)
    else $error("inner fields set on word without inner tuple");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(last_o))
    else $error("result word changed while waiting");

endmodule

bind bucketed_hash_join hjn_checker u_hjn_checker (.*);

[tb/bucketed_hash_join_chk.sv]
// Checker for the hash join engine: watches both queues, predicts and compares.
`timescale 1ns / 1ps
module bucketed_hash_join_chk
  import hjn_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned MAX_RUN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] tuple_key_i,
  input  logic [31:0] tuple_val_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] inner_key_i,
  input  logic [31:0] inner_val_i,
  input  logic [11:0] inner_index_i,
  input  logic [31:0] outer_key_i,
  input  logic [31:0] outer_val_i,
  input  logic        last_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  // shadow copy of the join table
  logic [31:0] tbl_key [TABLE_DEPTH];
  logic [31:0] tbl_val [TABLE_DEPTH];
  int unsigned fill_cnt;
  res_t        join_q[$];

  assign pending_o = join_q.size();

  function automatic res_t mk(status_e s, logic [31:0] ik, logic [31:0] iv,
                              logic [11:0] ix, logic [31:0] ok, logic [31:0] ov,
                              logic l);
    res_t r;
    r.status = s; r.inner_key = ik; r.inner_val = iv; r.inner_index = ix;
    r.outer_key = ok; r.outer_val = ov; r.last = l;
    return r;
  endfunction

  // walking the slots in arrival order is the same as walking the bucket chain
  task automatic predict_join(logic [1:0] req, logic [31:0] key, logic [31:0] val);
    int unsigned hits[$];
    if (req == REQ_BUILD) begin
      if (fill_cnt >= TABLE_DEPTH) begin
        join_q.push_back(mk(ST_FULL, key, val, '0, '0, '0, 1'b1));
      end else begin
        tbl_key[fill_cnt] = key;
        tbl_val[fill_cnt] = val;
        join_q.push_back(mk(ST_STORED, key, val, fill_cnt[11:0], '0, '0, 1'b1));
        fill_cnt++;
      end
    end else if (req == REQ_PROBE) begin
      for (int unsigned s = 0; s < fill_cnt && hits.size() <= MAX_RUN; s++)
        if (tbl_val[s] == val) hits.push_back(s);
      if (hits.size() == 0) begin
        join_q.push_back(mk(ST_NOMATCH, '0, '0, '0, key, val, 1'b1));
      end else if (hits.size() <= MAX_RUN) begin
        foreach (hits[k])
          join_q.push_back(mk(ST_MATCH, tbl_key[hits[k]], val, hits[k][11:0], key,
                              val, k == hits.size() - 1));
      end else begin
        for (int k = 0; k < MAX_RUN - 1; k++)
          join_q.push_back(mk(ST_MATCH, tbl_key[hits[k]], val, hits[k][11:0], key,
                              val, 1'b0));
        join_q.push_back(mk(ST_TRUNC, '0, '0, '0, key, val, 1'b1));
      end
    end else if (req == REQ_CLEAR) begin
      fill_cnt = 0;
      join_q.push_back(mk(ST_CLEARED, '0, '0, '0, '0, '0, 1'b1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      fill_cnt = 0;
      fail_cnt_o <= 0;
      join_q.delete();
    end else begin
      if (!empty_i && pop_i) begin
        got = mk(status_e'(status_i), inner_key_i, inner_val_i, inner_index_i,
                 outer_key_i, outer_val_i, last_i);
        if (join_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected word: %p", got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = join_q.pop_front();
          if (got !== want) begin
            if (fail_cnt_o < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (push_i && !full_i) predict_join(req_type_i, tuple_key_i, tuple_val_i);
    end
  end

endmodule

[tb/bucketed_hash_join_tb.sv]
// Testbench top: clock, reset, stimulus and verdict for the hash join engine.
`timescale 1ns / 1ps
module bucketed_hash_join_tb
  import hjn_pkg::*;
;

  localparam logic [1:0] ReqBad = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type_i = '0;
  logic [31:0] tuple_key_i = '0;
  logic [31:0] tuple_val_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] inner_key_o, inner_val_o, outer_key_o, outer_val_o;
  logic [11:0] inner_index_o;
  logic        last_o;
  int          fail_cnt, pending;
  int          send_idle = 0, recv_idle = 0;
  logic [31:0] val_pool[8];

  bucketed_hash_join DUT (.*);

  bucketed_hash_join_chk CHK (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .req_type_i, .tuple_key_i,
    .tuple_val_i, .empty_i(empty), .pop_i(pop), .status_i(status_o),
    .inner_key_i(inner_key_o), .inner_val_i(inner_val_o),
    .inner_index_i(inner_index_o), .outer_key_i(outer_key_o),
    .outer_val_i(outer_val_o), .last_i(last_o), .fail_cnt_o(fail_cnt),
    .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("bucketed_hash_join test failed");
    $finish;
  end

  // receiver: random pop at the falling edge
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // push stays high into the next word unless the sender idles
  task automatic send_word(logic [1:0] req, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= req;
    tuple_key_i <= key;
    tuple_val_i <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned p;
    logic [31:0] v;
    p = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? $urandom() : val_pool[$urandom_range(7)];
    if (p < 45) send_word(REQ_BUILD, $urandom(), v);
    else if (p < 90) send_word(REQ_PROBE, $urandom(), v);
    else if (p < 95) send_word(REQ_CLEAR, $urandom(), $urandom());
    else send_word(ReqBad, $urandom(), $urandom());
  endtask

  initial begin
    foreach (val_pool[i]) val_pool[i] = $urandom();
    val_pool[0] = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty probe, extremes, same bucket different value, unknown code
    send_word(REQ_PROBE, 32'h0, 32'h0);
    send_word(REQ_BUILD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_BUILD, 32'h0, 32'h0);
    send_word(REQ_BUILD, 32'h1234_5678, 32'h0000_0400);
    send_word(REQ_BUILD, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
    send_word(REQ_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_PROBE, 32'h5555_5555, 32'h0);
    send_word(REQ_PROBE, 32'hAAAA_AAAA, 32'h0000_07FF);
    send_word(ReqBad, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_CLEAR, 32'h0, 32'h0);
    send_word(REQ_PROBE, 32'h0, 32'hFFFF_FFFF);
    // run of exactly MAX_RUN matches, then one over it
    repeat (64) send_word(REQ_BUILD, $urandom(), 32'h0000_0077);
    send_word(REQ_PROBE, 32'h1, 32'h0000_0077);
    send_word(REQ_BUILD, $urandom(), 32'h0000_0077);
    send_word(REQ_PROBE, 32'h2, 32'h0000_0077);
    send_word(REQ_CLEAR, 32'h0, 32'h0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 52 : 0;
      recv_idle = (ph == 0) ? 52 : (ph == 1) ? 21 : 0;
      repeat (75) send_random();
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("bucketed_hash_join test passed");
    end else begin
      $display("bucketed_hash_join test failed");
    end
    $finish;
  end

endmodule
